>>> hdl/gti_pkg.sv
// gti_pkg: shared constants, op and status codes, and controller/datapath
// command and status structs for the gyro turn integrator
// no dependencies
package gti_pkg;

  // default fraction bits of the gyro rate (1/64 deg/s)
  localparam int RATE_FRAC_BITS_DEF = 6;

  // one million split as DIV_CONST << DIV_POW2
  localparam int DIV_CONST = 15625;
  localparam int DIV_POW2  = 6;

  // quotient divider: quotient bits, bits per cycle, remainder width
  localparam int Q_W       = 32;
  localparam int DIV_STEPS = 4;
  localparam int DIV_ITERS = Q_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);
  localparam int REM_W     = 14;

  localparam logic [31:0] TIMEOUT_RST = 32'd3000000;

  // op codes
  localparam logic [1:0] OP_RESET  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_RIGHT  = 2'd2;
  localparam logic [1:0] OP_LEFT   = 2'd3;

  // turn status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_TURNING = 2'd1;
  localparam logic [1:0] ST_REACHED = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic absv;
    logic prep;
    logic div;
    logic fin;
    logic commit;
  } gti_cmd_t;

  typedef struct packed {
    logic out_free;
  } gti_stat_t;

endpackage

>>> hdl/gti_ctrl.sv
// gti_ctrl: sequencer for one item at a time through the datapath
// depends on gti_pkg
module gti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gti_pkg::gti_stat_t stat,
  output gti_pkg::gti_cmd_t  cmd
);
  import gti_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_CHK  = 3'd7;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.absv   = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + DIV_CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule

>>> hdl/gti_dpath.sv
// gti_dpath: integrator state, rate multiply, magnitude, iterative constant
// divide, turn checks and the output register; depends on gti_pkg
module gti_dpath #(
  parameter int RATE_FRAC_BITS = gti_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  gti_pkg::gti_cmd_t  cmd,
  output gti_pkg::gti_stat_t stat,
  input  logic [1:0]         op,
  input  logic signed [15:0] gyro_rate,
  input  logic [31:0]        timestamp_us,
  input  logic signed [15:0] turn_degrees,
  input  logic [31:0]        timeout_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_deg,
  output logic signed [16:0] turn_rate,
  output logic [1:0]         turn_status
);
  import gti_pkg::*;

  localparam int SHIFT = DIV_POW2 + RATE_FRAC_BITS;
  localparam int MAG_W = 64 - SHIFT;
  localparam int DVD_W = Q_W + REM_W - 1;
  localparam logic [MAG_W-1:0] SAT_LIM = MAG_W'(DIV_CONST) << (Q_W - 1);
  localparam logic [REM_W:0]   DIV_K   = (REM_W + 1)'(DIV_CONST);

  // captured item
  logic [1:0]         op_r;
  logic signed [15:0] rate_r;
  logic [31:0]        ts_r;
  logic signed [15:0] deg_r;

  // integrator and turn state
  logic signed [15:0] rate_offset;
  logic [31:0]        last_time;
  logic [63:0]        angle_accum;
  logic signed [16:0] turn_target;
  logic [31:0]        turn_start_time;
  logic               turn_active;
  logic               turn_left;

  // work registers
  logic signed [16:0] corr;
  logic signed [49:0] prod;
  logic [31:0]        elapsed;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic               sat;
  logic [REM_W-1:0]   rem;
  logic [Q_W-1:0]     dq;
  logic signed [31:0] angle;

  logic               is_sample;
  logic [63:0]        abs_val;
  logic [REM_W-1:0]   rem_w;
  logic [Q_W-1:0]     dq_w;
  logic [REM_W:0]     trial;
  logic signed [31:0] tgt_ext;
  logic signed [16:0] deg_ext;
  logic               reached;

  assign is_sample     = (op_r == OP_SAMPLE);
  assign stat.out_free = !out_valid || out_ready;
  assign abs_val       = angle_accum[63] ? (~angle_accum + 64'd1) : angle_accum;
  assign tgt_ext       = {{15{turn_target[16]}}, turn_target};
  assign deg_ext       = {deg_r[15], deg_r};
  assign reached       = turn_left ? (angle <= tgt_ext) : (angle >= tgt_ext);

  // restoring divide, several quotient bits per cycle on a narrow remainder
  always_comb begin
    rem_w = rem;
    dq_w  = dq;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_w, dq_w[Q_W-1]};
      if (trial >= DIV_K) begin
        rem_w = REM_W'(trial - DIV_K);
        dq_w  = {dq_w[Q_W-2:0], 1'b1};
      end else begin
        rem_w = trial[REM_W-1:0];
        dq_w  = {dq_w[Q_W-2:0], 1'b0};
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      rate_r <= gyro_rate;
      ts_r   <= timestamp_us;
      deg_r  <= turn_degrees;
    end
    if (cmd.mul) begin
      corr <= 17'(rate_r) - 17'(rate_offset);
      prod <= (17'(rate_r) - 17'(rate_offset)) * $signed({1'b0, ts_r - last_time});
    end
    if (cmd.acc) begin
      elapsed <= ts_r - turn_start_time;
    end
    if (cmd.absv) begin
      neg <= angle_accum[63];
      mag <= abs_val[63:SHIFT];
    end
    if (cmd.prep) begin
      sat <= (mag >= SAT_LIM);
      rem <= REM_W'(mag[DVD_W-1:Q_W]);
      dq  <= mag[Q_W-1:0];
    end
    if (cmd.div) begin
      rem <= rem_w;
      dq  <= dq_w;
    end
    if (cmd.fin) begin
      if (sat) begin
        angle <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        angle <= neg ? -$signed(dq) : $signed(dq);
      end
    end
    if (cmd.commit) begin
      angle_deg <= angle;
      turn_rate <= is_sample ? corr : 17'sd0;
    end
  end

  // model state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_offset     <= '0;
      last_time       <= '0;
      angle_accum     <= '0;
      turn_target     <= '0;
      turn_start_time <= '0;
      turn_active     <= 1'b0;
      turn_left       <= 1'b0;
      out_valid       <= 1'b0;
      turn_status     <= ST_NONE;
    end else begin
      if (cmd.acc) begin
        last_time <= ts_r;
        if (is_sample) begin
          angle_accum <= angle_accum + {{14{prod[49]}}, prod};
        end else begin
          angle_accum <= '0;
          rate_offset <= rate_r;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        case (op_r)
          OP_SAMPLE: begin
            if (!turn_active) begin
              turn_status <= ST_NONE;
            end else if (reached) begin
              turn_status <= ST_REACHED;
              turn_active <= 1'b0;
            end else if (elapsed >= timeout_us) begin
              turn_status <= ST_TIMEOUT;
              turn_active <= 1'b0;
            end else begin
              turn_status <= ST_TURNING;
            end
          end
          OP_RIGHT, OP_LEFT: begin
            turn_status     <= ST_TURNING;
            turn_active     <= 1'b1;
            turn_left       <= (op_r == OP_LEFT);
            turn_target     <= (op_r == OP_LEFT) ? -deg_ext : deg_ext;
            turn_start_time <= ts_r;
          end
          default: begin
            turn_status <= ST_NONE;
            turn_active <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

>>> hdl/gyro_turn_integrator.sv
// gyro_turn_integrator: one item in, one result out; each item is taken
// whole through the sequencer states before a new item is accepted, and
// the sequence waits in its last state while an unread result holds the output
// the quotient divider (4 bits a cycle) takes most of the sequencer states
// rst is synchronous, active high: clears offset, time, accumulator, turn
// state, out_valid and turn_status, and loads timeout_us with 3000000
module gyro_turn_integrator #(
  parameter int RATE_FRAC_BITS = gti_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // item input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [15:0] gyro_rate,
  input  logic [31:0]        timestamp_us,
  input  logic signed [15:0] turn_degrees,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_deg,
  output logic signed [16:0] turn_rate,
  output logic [1:0]         turn_status,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gti_pkg::*;

  gti_cmd_t    cmd;
  gti_stat_t   stat;
  logic [31:0] timeout_us;
  logic        cfg_sel;

  // register 0 lives at byte address 0, the next word is outside the map
  assign cfg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? timeout_us : 32'd0;

  // timeout register, written in the access phase of a write
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      timeout_us <= pwdata;
    end
  end

  // sequencer: idle, multiply, accumulate, magnitude, divider setup,
  // divide iterations, sign and saturation, turn check and output write
  gti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: the integrator state, the shared arithmetic and the output
  // register, which lets a result wait while the next item is accepted
  gti_dpath #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .gyro_rate    (gyro_rate),
    .timestamp_us (timestamp_us),
    .turn_degrees (turn_degrees),
    .timeout_us   (timeout_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .angle_deg    (angle_deg),
    .turn_rate    (turn_rate),
    .turn_status  (turn_status)
  );

endmodule

>>> hdl/gti_checker.sv
// gti_checker: port-level checks on the gyro turn integrator over time
// bound to gyro_turn_integrator; no package dependency
module gti_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] angle_deg,
  input logic [16:0] turn_rate,
  input logic [1:0]  turn_status
);

  // one item at a time: input closes right after an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again in the cycle after an item");

  // no result can appear in the cycle after an item is taken, if none was waiting
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too soon after item");

  // a waiting result holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_deg)
      && $stable(turn_rate) && $stable(turn_status))
    else $error("stalled result changed");

  // after reset the block is empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind gyro_turn_integrator gti_checker u_gti_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .angle_deg   (angle_deg),
  .turn_rate   (turn_rate),
  .turn_status (turn_status)
);
